FILE: design/fif_pkg.sv
`default_nettype none

package fif_pkg;

  // Digit storage: octal of a 64-bit value needs the most digits.
  localparam int NUM_DIGITS = 22;
  localparam int BCD_DIGITS = 20;
  localparam int DIG_IDX_W  = 5;

  // Radix codes; the spare code is taken as hexadecimal.
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Size codes for the mask applied after the sign test.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // ASCII codes used in the field.
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  radix_select;
    logic [6:0]  field_width;
    logic [1:0]  size_code;
    logic        left_justify;
    logic        plus_sign;
    logic        blank_sign;
    logic        radix_prefix;
    logic        zero_pad;
    logic        is_signed;
    logic        upper_case;
  } fif_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } fif_out_t;

  // Layout of one field: region boundaries by character position.
  typedef struct packed {
    logic [6:0] pre_start;
    logic [6:0] pre_end;
    logic [6:0] dig_start;
    logic [6:0] dig_end;
    logic [7:0] sign_ch;
    logic       ucase;
  } fif_plan_t;

endpackage

`default_nettype wire

FILE: design/fif_digit_unit.sv
`default_nettype none

module fif_digit_unit
  import fif_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] mag,
  input  wire logic [1:0]  radix,
  input  wire logic [1:0]  size,
  output logic             done,
  output digit_vec_t       digits
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] shreg_r, shreg_nxt;
  digit_vec_t  dig_r, dig_nxt;
  digit_vec_t  adj, shifted;
  logic [65:0] mag_ext;
  logic [63:0] aligned;
  logic [6:0]  bits;

  // One double-dabble step: add three to every BCD digit of five or more, then shift in.
  always_comb begin
    adj     = dig_r;
    shifted = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dig_r[i] >= 4'd5) begin
        adj[i] = dig_r[i] + 4'd3;
      end
    end
    shifted[0] = {adj[0][2:0], shreg_r[63]};
    for (int i = 1; i < BCD_DIGITS; i++) begin
      shifted[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // The masked value is left-aligned so only its own bits are shifted in.
  always_comb begin
    mag_ext = {2'b00, mag};
    case (size)
      SIZE_8: begin
        bits    = 7'd8;
        aligned = {mag[7:0], 56'd0};
      end
      SIZE_16: begin
        bits    = 7'd16;
        aligned = {mag[15:0], 48'd0};
      end
      SIZE_32: begin
        bits    = 7'd32;
        aligned = {mag[31:0], 32'd0};
      end
      default: begin
        bits    = 7'd64;
        aligned = mag;
      end
    endcase
  end

  // Octal and hex digits are plain bit slices; decimal iterates once per bit.
  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    shreg_nxt = shreg_r;
    dig_nxt   = dig_r;
    if (start) begin
      case (radix)
        RADIX_OCT: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            dig_nxt[i] = {1'b0, mag_ext[3*i +: 3]};
          end
        end
        RADIX_DEC: begin
          dig_nxt   = '0;
          busy_nxt  = 1'b1;
          cnt_nxt   = bits;
          shreg_nxt = aligned;
        end
        default: begin
          dig_nxt = '0;
          for (int i = 0; i < 16; i++) begin
            dig_nxt[i] = mag[4*i +: 4];
          end
        end
      endcase
    end else if (busy_r) begin
      dig_nxt   = shifted;
      shreg_nxt = {shreg_r[62:0], 1'b0};
      cnt_nxt   = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    shreg_r <= shreg_nxt;
    dig_r   <= dig_nxt;
  end

  assign done   = !busy_r;
  assign digits = dig_r;

endmodule

`default_nettype wire

FILE: design/fif_char_gen.sv
`default_nettype none

module fif_char_gen
  import fif_pkg::*;
(
  input  wire fif_plan_t  plan,
  input  wire logic [6:0] pos,
  input  wire digit_vec_t digits,
  output logic [7:0]      ch
);

  logic [DIG_IDX_W-1:0] idx;
  logic [6:0]           idx_full;
  digit_t               d;
  logic [7:0]           dig_ch;

  // Digits are stored least significant first, so count down from the field end.
  assign idx_full = plan.dig_end - 7'd1 - pos;
  assign idx      = idx_full[DIG_IDX_W-1:0];
  assign d        = digits[idx];

  always_comb begin
    if (d < 4'd10) begin
      dig_ch = CH_ZERO + {4'd0, d};
    end else if (plan.ucase) begin
      dig_ch = CH_UA + {4'd0, d} - 8'd10;
    end else begin
      dig_ch = CH_LA + {4'd0, d} - 8'd10;
    end
  end

  // Select the region that the position falls into.
  always_comb begin
    if (pos < plan.pre_start) begin
      ch = CH_SPACE;
    end else if (pos < plan.pre_end) begin
      if (pos == plan.pre_start) begin
        ch = (plan.sign_ch != CH_NONE) ? plan.sign_ch : CH_ZERO;
      end else begin
        ch = plan.ucase ? CH_UX : CH_LX;
      end
    end else if (pos < plan.dig_start) begin
      ch = CH_ZERO;
    end else if (pos < plan.dig_end) begin
      ch = dig_ch;
    end else begin
      ch = CH_SPACE;
    end
  end

endmodule

`default_nettype wire

FILE: design/format_integer_field_unit.sv
// Channel  | Ports                          | Moves
// ---------+--------------------------------+---------------------------------
// input    | in_valid, in_stall, in_data    | one conversion request
// output   | out_valid, out_stall, out_data | one character, last_char on end
//
// A request yields len characters, where len is the field length; decimal first
// shifts the masked bits (8, 16, 32 or 64) through the BCD unit. Characters
// leave at one per cycle, while out_stall is low, via a single output register.
// in_stall is high from acceptance until the last character is registered.
// Reset is synchronous and active low; it clears the sequencer and output valid.
`default_nettype none

module format_integer_field_unit
  import fif_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire fif_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output fif_out_t     out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PLAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  state_t     state_r, state_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [6:0] len_r, len_nxt;
  fif_plan_t  plan_r, plan_nxt;
  logic [7:0] sign_ch_r, sign_ch_nxt;
  logic [1:0] plen_r, plen_nxt;
  logic       ucase_r, left_r, zpad_r;
  logic [6:0] width_r, width_nxt;
  logic       out_valid_r, out_valid_nxt;
  fif_out_t   out_data_r, out_data_nxt;

  logic        accept;
  logic [63:0] mag_full, mag;
  logic        dig_done;
  digit_vec_t  digits;
  logic [4:0]  nd;
  logic [6:0]  total, pad;
  logic [7:0]  ch;
  logic        out_adv, last;

  assign accept = in_valid && !in_stall;

  // Sign test on the full value, then the mask.
  always_comb begin
    mag_full = (in_data.is_signed && in_data.value[63]) ? (64'd0 - in_data.value)
                                                        : in_data.value;
    case (in_data.size_code)
      SIZE_8:  mag = {56'd0, mag_full[7:0]};
      SIZE_16: mag = {48'd0, mag_full[15:0]};
      SIZE_32: mag = {32'd0, mag_full[31:0]};
      default: mag = mag_full;
    endcase
  end

  // Sign character, sign or radix prefix length, and field width clamped to MAX_WIDTH.
  always_comb begin
    sign_ch_nxt = CH_NONE;
    plen_nxt    = 2'd0;
    if (in_data.is_signed) begin
      if (in_data.value[63]) begin
        sign_ch_nxt = CH_MINUS;
      end else if (in_data.plus_sign) begin
        sign_ch_nxt = CH_PLUS;
      end else if (in_data.blank_sign) begin
        sign_ch_nxt = CH_SPACE;
      end
      plen_nxt = (sign_ch_nxt != CH_NONE) ? 2'd1 : 2'd0;
    end else if (in_data.radix_prefix && (mag != 64'd0) &&
                 (in_data.radix_select != RADIX_DEC)) begin
      plen_nxt = (in_data.radix_select == RADIX_OCT) ? 2'd1 : 2'd2;
    end
    width_nxt = (in_data.field_width > MaxW) ? MaxW : in_data.field_width;
  end

  fif_digit_unit u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .mag    (mag),
    .radix  (in_data.radix_select),
    .size   (in_data.size_code),
    .done   (dig_done),
    .digits (digits)
  );

  // Field layout: significant digit count, padding and region boundaries.
  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
    total = {2'd0, nd} + {5'd0, plen_r};
    pad   = (width_r > total) ? (width_r - total) : 7'd0;
    plan_nxt.sign_ch = sign_ch_r;
    plan_nxt.ucase   = ucase_r;
    if (left_r) begin
      plan_nxt.pre_start = 7'd0;
      plan_nxt.dig_start = {5'd0, plen_r};
    end else if (zpad_r) begin
      plan_nxt.pre_start = 7'd0;
      plan_nxt.dig_start = {5'd0, plen_r} + pad;
    end else begin
      plan_nxt.pre_start = pad;
      plan_nxt.dig_start = pad + {5'd0, plen_r};
    end
    plan_nxt.pre_end = plan_nxt.pre_start + {5'd0, plen_r};
    plan_nxt.dig_end = plan_nxt.dig_start + {2'd0, nd};
    len_nxt          = total + pad;
  end

  fif_char_gen u_char (
    .plan   (plan_r),
    .pos    (pos_r),
    .digits (digits),
    .ch     (ch)
  );

  assign out_adv = !out_valid_r || !out_stall;
  assign last    = (pos_r == (len_r - 7'd1));

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (dig_done) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        pos_nxt   = 7'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = ch;
          out_data_nxt.last_char = last;
          pos_nxt                = pos_r + 7'd1;
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request settings are captured at acceptance; the plan is built once.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      sign_ch_r <= sign_ch_nxt;
      plen_r    <= plen_nxt;
      width_r   <= width_nxt;
      ucase_r   <= in_data.upper_case;
      left_r    <= in_data.left_justify;
      zpad_r    <= in_data.zero_pad;
    end
    if (state_r == ST_PLAN) begin
      plan_r <= plan_nxt;
      len_r  <= len_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: design/fif_checker.sv
`default_nettype none

module fif_checker
  import fif_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire fif_out_t out_data
);

  // A held character stays put until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled character changed");

  // Only one request is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while converting");

  // Characters of one field follow each other without a gap.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_char |=> out_valid)
    else $error("gap inside a field");

  // A new request is taken only once the previous field's last character is registered.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid || out_data.last_char)
    else $error("request taken in the middle of a field");

  // The character code is never NUL.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.character != CH_NONE)
    else $error("empty character emitted");

endmodule

bind format_integer_field_unit fif_checker u_fif_checker (.*);

`default_nettype wire
